// ===== hw/rtl/buddy_allocator_tree_assert.svh =====
// ============================================================================
// Buddy allocator assertion macros
// Shared property forms for the buddy allocator checks.
// ============================================================================
`ifndef BUDDY_ALLOCATOR_TREE_ASSERT_SVH
`define BUDDY_ALLOCATOR_TREE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication, disabled during reset
`define BAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// ===== hw/rtl/bat_pkg.sv =====
// ============================================================================
// Buddy allocator package
// Widths, codes and the controller/datapath interface types.
// ============================================================================
`default_nettype none

package bat_pkg;

    // Fixed field widths
    localparam int SHIFT_W    = 5;
    localparam int BYTES_W    = 27;
    localparam int OFF_W      = 26;
    localparam int STAT_W     = 2;
    localparam int NODE_W     = 5;
    localparam int LEVELS_DEF = 10;

    // Largest usable block shift
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(16);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);

    // Node value marking a used region
    localparam logic [NODE_W-1:0] NODE_USED = '1;

    // Opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = STAT_W'(2);

    // Controller to datapath commands
    typedef struct packed {
        logic clr;       // write one node of the clearing pass
        logic load;      // latch the accepted request
        logic decode;    // size / offset decode, first tree read
        logic root;      // check root for space
        logic desc;      // one level of the descent
        logic mark;      // mark target node used
        logic climb;     // one level of the free search
        logic up;        // recompute one ancestor
        logic out_load;  // move result into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;     // last node of clearing pass
        logic is_free;      // request is a free
        logic oob;          // free offset beyond the pool
        logic no_space;     // root cannot hold the request
        logic at_target;    // current level equals wanted level
        logic node_used;    // node read holds the used mark
        logic at_root;      // current node is the root
        logic parent_root;  // parent of current node is the root
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/buddy_allocator_tree.sv =====
// ============================================================================
// Buddy allocator tree
// Binary-tree buddy allocator with request/result channels.
// ============================================================================
// The pool holds 2^LEVELS blocks of 2^block_shift bytes (shift capped at 16).
// After reset the block runs a clearing pass over every node of the tree
// before it takes its first request; configuration writes are always accepted,
// but belong between requests, while no request is in flight.
// One request is worked at a time and gives one result.
// The tree sits in a single RAM with one read and one write port, and the
// walk costs one read per tree level. A finished result waits in the
// output register, so the block can accept the next request meanwhile.
`default_nettype none

`include "buddy_allocator_tree_assert.svh"

module buddy_allocator_tree #(
    parameter int LEVELS = bat_pkg::LEVELS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bat_pkg::SHIFT_W-1:0] i_cfg_block_shift,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_opcode,
    input  wire logic [bat_pkg::BYTES_W-1:0] i_request_bytes,
    input  wire logic [bat_pkg::OFF_W-1:0]   i_free_offset,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [bat_pkg::STAT_W-1:0]  o_status,
    output logic      [bat_pkg::OFF_W-1:0]   o_region_offset
);

    import bat_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_cfg_we;

    // Config register is always writable
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    bat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bat_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_data      (i_cfg_block_shift),
        .i_opcode        (i_opcode),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_status        (o_status),
        .o_region_offset (o_region_offset)
    );

    // Controller issues at most one command per cycle
    `BAT_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))
    // Block is busy the cycle after taking a request
    `BAT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
                     i_in_valid && o_in_ready, !o_in_ready)
    // Failed results carry a zero offset
    `BAT_ASSERT_NOW(a_fail_zero_off, i_clk, i_rst_n,
                    o_out_valid && (o_status != ST_OK), o_region_offset == '0)
    // Only defined status codes leave the block
    `BAT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid,
                    (o_status == ST_OK) || (o_status == ST_NO_SPACE) ||
                    (o_status == ST_NOT_ALLOC))

endmodule

`default_nettype wire

// ===== hw/rtl/bat_ram.sv =====
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module bat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bat_ctrl.sv =====
// ============================================================================
// Buddy allocator controller
// Sequences clearing, descent, marking and ancestor update.
// ============================================================================
`default_nettype none

module bat_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire bat_pkg::t_sts i_sts,
    output bat_pkg::t_cmd      o_cmd
);

    import bat_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ROOT,
        S_DESC,
        S_MARK,
        S_CLIMB,
        S_UP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    t_cmd   w_cmd;
    logic   w_in_ready;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld;
        w_cmd      = '0;
        w_in_ready = 1'b0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                w_cmd.decode = 1'b1;
                if (i_sts.is_free) begin
                    n_state = i_sts.oob ? S_DONE : S_CLIMB;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                w_cmd.root = 1'b1;
                if (i_sts.no_space) begin
                    n_state = S_DONE;
                end else if (i_sts.at_target) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_DESC;
                end
            end
            S_DESC: begin
                w_cmd.desc = 1'b1;
                if (i_sts.at_target) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                w_cmd.mark = 1'b1;
                n_state    = i_sts.at_root ? S_DONE : S_UP;
            end
            S_CLIMB: begin
                w_cmd.climb = 1'b1;
                if (i_sts.node_used) begin
                    n_state = i_sts.at_root ? S_DONE : S_UP;
                end else if (i_sts.at_root) begin
                    n_state = S_DONE;
                end
            end
            S_UP: begin
                w_cmd.up = 1'b1;
                if (i_sts.parent_root) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

// ===== hw/rtl/bat_dp.sv =====
// ============================================================================
// Buddy allocator datapath
// Tree memory, node walk registers, size decode and result register.
// ============================================================================
`default_nettype none

module bat_dp #(
    parameter int LEVELS = bat_pkg::LEVELS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bat_pkg::SHIFT_W-1:0]  i_cfg_data,
    input  wire logic                         i_opcode,
    input  wire logic [bat_pkg::BYTES_W-1:0]  i_request_bytes,
    input  wire logic [bat_pkg::OFF_W-1:0]    i_free_offset,
    input  wire bat_pkg::t_cmd                i_cmd,
    output bat_pkg::t_sts                     o_sts,
    output logic      [bat_pkg::STAT_W-1:0]   o_status,
    output logic      [bat_pkg::OFF_W-1:0]    o_region_offset
);

    import bat_pkg::*;

    localparam int IDX_W     = LEVELS + 1;
    localparam int NODES     = 2 ** (LEVELS + 1) - 1;
    localparam int LEAF_BASE = 2 ** LEVELS - 1;

    // Node fits a run of 2^want blocks
    function automatic logic f_fits(logic [NODE_W-1:0] v, logic [NODE_W-1:0] want);
        return (v != NODE_USED) && (v >= want);
    endfunction

    // Larger of two nodes, used mark below every level
    function automatic logic [NODE_W-1:0] f_max_node(logic [NODE_W-1:0] a,
                                                     logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] r;
        if (a == NODE_USED) begin
            r = b;
        end else if (b == NODE_USED) begin
            r = a;
        end else begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

    // Ceiling log2 of a byte count, 0 for 0 and 1
    function automatic logic [NODE_W-1:0] f_clog2_bytes(logic [BYTES_W-1:0] b);
        logic [BYTES_W-1:0] m;
        logic [NODE_W-1:0]  r;
        m = b - 1'b1;
        r = '0;
        if (b > BYTES_W'(1)) begin
            for (int i = 0; i < BYTES_W; i++) begin
                if (m[i]) begin
                    r = NODE_W'(i + 1);
                end
            end
        end
        return r;
    endfunction

    // Control registers
    logic [SHIFT_W-1:0] r_shift;
    logic [IDX_W-1:0]   r_clr_idx;
    logic [NODE_W-1:0]  r_clr_lvl;

    // Request and walk registers
    logic               r_op;
    logic [NODE_W-1:0]  r_clog;
    logic [OFF_W-1:0]   r_offset;
    logic [NODE_W-1:0]  r_want;
    logic [IDX_W-1:0]   r_idx;
    logic [NODE_W-1:0]  r_lvl;
    logic [NODE_W-1:0]  r_val;
    logic [STAT_W-1:0]  r_status;
    logic [OFF_W-1:0]   r_res_off;
    logic [STAT_W-1:0]  r_o_status;
    logic [OFF_W-1:0]   r_o_off;

    // Memory ports
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [NODE_W-1:0]  w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [NODE_W-1:0]  w_rdata;

    // Combinational helpers
    logic [SHIFT_W-1:0] w_sh;
    logic [NODE_W-1:0]  w_want;
    logic [OFF_W-1:0]   w_fblk;
    logic               w_oob;
    logic [IDX_W-1:0]   w_leaf;
    logic               w_fits;
    logic [IDX_W-1:0]   w_chosen;
    logic [IDX_W-1:0]   w_child;
    logic [IDX_W-1:0]   w_sib;
    logic [IDX_W-1:0]   w_parent;
    logic [IDX_W-1:0]   w_psib;
    logic               w_merge;
    logic [NODE_W-1:0]  w_new;
    logic [LEVELS-1:0]  w_blk;
    logic [OFF_W-1:0]   w_off;
    logic [IDX_W:0]     w_clr_p;
    logic               w_clr_pow2;
    logic               w_no_space;

    bat_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Decode of size and offset
    always_comb begin
        w_sh       = (r_shift > SHIFT_MAX) ? SHIFT_MAX : r_shift;
        w_want     = (r_clog > NODE_W'(w_sh)) ? (r_clog - NODE_W'(w_sh)) : '0;
        w_fblk     = r_offset >> w_sh;
        w_oob      = (w_fblk >> LEVELS) != '0;
        w_leaf     = IDX_W'(w_fblk[LEVELS-1:0]) + IDX_W'(LEAF_BASE);
        w_no_space = (r_want > NODE_W'(LEVELS)) || !f_fits(w_rdata, r_want);
    end

    // Tree navigation
    always_comb begin
        w_fits   = f_fits(w_rdata, r_want);
        w_chosen = w_fits ? r_idx : IDX_W'(r_idx + 1'b1);
        w_child  = IDX_W'({w_chosen, 1'b1});
        w_sib    = r_idx[0] ? IDX_W'(r_idx + 1'b1) : IDX_W'(r_idx - 1'b1);
        w_parent = IDX_W'((r_idx - 1'b1) >> 1);
        w_psib   = w_parent[0] ? IDX_W'(w_parent + 1'b1) : IDX_W'(w_parent - 1'b1);
        w_merge  = (r_op == OP_FREE) && (r_val == r_lvl) && (w_rdata == r_lvl);
        w_new    = w_merge ? NODE_W'(r_lvl + 1'b1) : f_max_node(r_val, w_rdata);
        // block index of the target node, then byte offset
        w_blk    = LEVELS'(IDX_W'(r_idx + 1'b1)) << r_want;
        w_off    = OFF_W'(w_blk) << w_sh;
    end

    // Clearing pass level step: level drops when the next index starts a row
    always_comb begin
        w_clr_p    = {1'b0, r_clr_idx} + (IDX_W + 1)'(2);
        w_clr_pow2 = (w_clr_p & (w_clr_p - 1'b1)) == '0;
    end

    // Memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_lvl;
        w_raddr = '0;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = r_clr_lvl;
        end
        if (i_cmd.decode) begin
            w_raddr = (r_op == OP_FREE) ? w_leaf : '0;
        end
        if (i_cmd.root) begin
            w_raddr = IDX_W'(1);
        end
        if (i_cmd.desc) begin
            w_raddr = w_child;
        end
        if (i_cmd.mark) begin
            w_we    = 1'b1;
            w_wdata = NODE_USED;
            w_raddr = w_sib;
        end
        if (i_cmd.climb) begin
            w_we    = (w_rdata == NODE_USED);
            w_raddr = (w_rdata == NODE_USED) ? w_sib : w_parent;
        end
        if (i_cmd.up) begin
            w_we    = 1'b1;
            w_waddr = w_parent;
            w_wdata = w_new;
            w_raddr = w_psib;
        end
    end

    // Config and clearing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= SHIFT_RESET;
            r_clr_idx <= '0;
            r_clr_lvl <= NODE_W'(LEVELS);
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_clr_idx <= IDX_W'(r_clr_idx + 1'b1);
                if (w_clr_pow2) begin
                    r_clr_lvl <= NODE_W'(r_clr_lvl - 1'b1);
                end
            end
        end
    end

    // Request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_clog   <= f_clog2_bytes(i_request_bytes);
            r_offset <= i_free_offset;
        end
        if (i_cmd.decode) begin
            r_want    <= w_want;
            r_status  <= ST_NOT_ALLOC;
            r_res_off <= '0;
            if (r_op == OP_FREE) begin
                r_idx <= w_leaf;
                r_lvl <= '0;
            end else begin
                r_idx <= '0;
                r_lvl <= NODE_W'(LEVELS);
            end
        end
        if (i_cmd.root) begin
            if (w_no_space) begin
                r_status <= ST_NO_SPACE;
            end else if (r_lvl != r_want) begin
                r_idx <= IDX_W'(1);
                r_lvl <= NODE_W'(LEVELS - 1);
            end
        end
        if (i_cmd.desc) begin
            if (r_lvl == r_want) begin
                r_idx <= w_chosen;
            end else begin
                r_idx <= w_child;
                r_lvl <= NODE_W'(r_lvl - 1'b1);
            end
        end
        if (i_cmd.mark) begin
            r_val     <= NODE_USED;
            r_status  <= ST_OK;
            r_res_off <= w_off;
        end
        if (i_cmd.climb) begin
            if (w_rdata == NODE_USED) begin
                r_val    <= r_lvl;
                r_status <= ST_OK;
            end else if (r_idx != '0) begin
                r_idx <= w_parent;
                r_lvl <= NODE_W'(r_lvl + 1'b1);
            end
        end
        if (i_cmd.up) begin
            r_val <= w_new;
            r_idx <= w_parent;
            r_lvl <= NODE_W'(r_lvl + 1'b1);
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_off    <= r_res_off;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.clr_last    = (r_clr_idx == IDX_W'(NODES - 1));
        o_sts.is_free     = (r_op == OP_FREE);
        o_sts.oob         = w_oob;
        o_sts.no_space    = w_no_space;
        o_sts.at_target   = (r_lvl == r_want);
        o_sts.node_used   = (w_rdata == NODE_USED);
        o_sts.at_root     = (r_idx == '0);
        o_sts.parent_root = (w_parent == '0);
    end

    assign o_status        = r_o_status;
    assign o_region_offset = r_o_off;

endmodule

`default_nettype wire

// ===== verif/tb_buddy_allocator_tree.sv =====
// ============================================================================
// Buddy allocator tree testbench
// Drives allocate and free requests through the request channel, keeps its
// own copy of the allocation tree to predict every result, and checks each
// result in order. A short directed table covers the pool edges, the error
// codes and the block_shift cap. Random phases under several block_shift
// settings then follow, with frees aimed mostly at live regions.
// ============================================================================
module tb_buddy_allocator_tree;

    import bat_pkg::*;

    localparam int LEVELS       = LEVELS_DEF;
    localparam int NODE_CNT     = (2 << LEVELS) - 1;
    localparam int POOL_BLOCKS  = 1 << LEVELS;
    localparam int NODE_TAKEN   = -1;
    localparam int MAX_BYTES    = 67108864;
    localparam int PHASE_ITEMS  = 170;
    localparam int STALL_CYCLES = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT      = 6000000;

    typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_SHIFT} t_row_kind;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  region_offset;
    } t_result;

    // one directed request: arg is the byte count, the offset or the shift
    typedef struct packed {
        t_row_kind          kind;
        logic [BYTES_W-1:0] arg;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  region;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SHIFT_W-1:0] i_cfg_block_shift = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_opcode = OP_ALLOC;
    logic [BYTES_W-1:0] i_request_bytes = '0;
    logic [OFF_W-1:0]   i_free_offset = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [OFF_W-1:0]   o_region_offset;

    buddy_allocator_tree #(
        .LEVELS(LEVELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_block_shift(i_cfg_block_shift),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_request_bytes  (i_request_bytes),
        .i_free_offset    (i_free_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_region_offset  (o_region_offset)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow allocator state
    // ------------------------------------------------------------------------
    // node levels kept as ints so the taken mark compares below every level
    int           level_tree [0:NODE_CNT-1];
    logic [SHIFT_W-1:0] shadow_shift;
    // live regions, in blocks, for aiming frees
    longint       live_blk [$];
    int           live_lvl [$];

    t_result      pending_results [$];
    int           errors = 0;
    int           results_seen = 0;
    int           n_requests = 0;
    int           n_settings = 0;
    int           n_alloc_ok = 0;
    int           n_no_space = 0;
    int           n_free_ok = 0;
    int           n_not_alloc = 0;
    bit           random_phase = 1'b0;
    bit           pressure_done = 1'b0;

    function automatic int eff_shift();
        return (shadow_shift > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(shadow_shift);
    endfunction

    function automatic int larger(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Work out the result of one request and update the shadow tree
    function automatic t_result allocate_or_free(logic op, logic [BYTES_W-1:0] bytes,
                                                 logic [OFF_W-1:0] off);
        t_result res;
        int      sh;
        int      want;
        int      lv;
        int      idx;
        int      n;
        int      l;
        int      r;
        int      k;
        bit      found;
        longint  blocks;
        longint  blk;

        sh = eff_shift();
        res.status = ST_OK;
        res.region_offset = '0;
        if (op == OP_ALLOC) begin
            blocks = (longint'(bytes) + (longint'(1) << sh) - 1) >> sh;
            if (blocks == 0)
                blocks = 1;
            want = 0;
            while ((longint'(1) << want) < blocks)
                want++;
            if (want > LEVELS || level_tree[0] < want) begin
                res.status = ST_NO_SPACE;
            end else begin
                // left-first descent to the wanted level
                idx = 0;
                lv = LEVELS;
                while (lv != want) begin
                    idx = 2 * idx + 1;
                    if (level_tree[idx] < want)
                        idx++;
                    lv--;
                end
                level_tree[idx] = NODE_TAKEN;
                blk = ((longint'(idx) + 1) << want) - POOL_BLOCKS;
                live_blk.push_back(blk);
                live_lvl.push_back(want);
                while (idx != 0) begin
                    idx = (idx - 1) / 2;
                    level_tree[idx] = larger(level_tree[2 * idx + 1],
                                             level_tree[2 * idx + 2]);
                end
                res.region_offset = OFF_W'(blk << sh);
            end
        end else begin
            blk = longint'(off) >> sh;
            if (blk >= POOL_BLOCKS) begin
                res.status = ST_NOT_ALLOC;
            end else begin
                // climb to the taken ancestor
                idx = int'(blk) + POOL_BLOCKS - 1;
                n = 0;
                found = 1'b1;
                while (found && level_tree[idx] != NODE_TAKEN) begin
                    n++;
                    if (idx == 0)
                        found = 1'b0;
                    else
                        idx = (idx - 1) / 2;
                end
                if (!found) begin
                    res.status = ST_NOT_ALLOC;
                end else begin
                    // restore it and merge buddies on the way up
                    level_tree[idx] = n;
                    while (idx != 0) begin
                        idx = (idx - 1) / 2;
                        n++;
                        l = level_tree[2 * idx + 1];
                        r = level_tree[2 * idx + 2];
                        level_tree[idx] = (l == n - 1 && r == n - 1) ? n : larger(l, r);
                    end
                    for (k = live_blk.size() - 1; k >= 0; k--) begin
                        if (blk >= live_blk[k] &&
                            blk < live_blk[k] + (longint'(1) << live_lvl[k])) begin
                            live_blk.delete(k);
                            live_lvl.delete(k);
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [BYTES_W-1:0] bytes,
                                input logic [OFF_W-1:0] off, input logic typed,
                                input t_result typed_res, input bit steady);
        int      gap;
        t_result res;

        gap = pick_gap(steady);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_request_bytes <= bytes;
        i_free_offset   <= off;
        do @(posedge i_clk); while (!o_in_ready);
        res = allocate_or_free(op, bytes, off);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
        n_requests++;
        if (res.status == ST_NO_SPACE)
            n_no_space++;
        else if (res.status == ST_NOT_ALLOC)
            n_not_alloc++;
        else if (op == OP_ALLOC)
            n_alloc_ok++;
        else
            n_free_ok++;
    endtask

    // write block_shift once every outstanding request has its result
    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_block_shift <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        shadow_shift  = value;
        n_settings++;
    endtask

    // pool edges, error codes and the shift cap; starts at the reset shift
    t_dir_row dir_rows [0:24] = '{
        '{ROW_ALLOC, 27'd0,        1'b1, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd1,        1'b1, ST_OK,        26'd64},
        '{ROW_FREE,  27'd64,       1'b1, ST_OK,        26'd0},
        '{ROW_FREE,  27'd64,       1'b1, ST_NOT_ALLOC, 26'd0},
        '{ROW_FREE,  27'd65536,    1'b1, ST_NOT_ALLOC, 26'd0},
        '{ROW_FREE,  27'h3FFFFFF,  1'b1, ST_NOT_ALLOC, 26'd0},
        '{ROW_ALLOC, 27'd67108864, 1'b1, ST_NO_SPACE,  26'd0},
        '{ROW_ALLOC, 27'd67108863, 1'b1, ST_NO_SPACE,  26'd0},
        '{ROW_ALLOC, 27'd65536,    1'b1, ST_NO_SPACE,  26'd0},
        '{ROW_ALLOC, 27'd100,      1'b0, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd3000,     1'b0, ST_OK,        26'd0},
        '{ROW_FREE,  27'd0,        1'b1, ST_OK,        26'd0},
        '{ROW_FREE,  27'd130,      1'b0, ST_OK,        26'd0},
        '{ROW_FREE,  27'd5000,     1'b0, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd65536,    1'b1, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd0,        1'b1, ST_NO_SPACE,  26'd0},
        '{ROW_FREE,  27'd32768,    1'b1, ST_OK,        26'd0},
        '{ROW_SHIFT, 27'd31,       1'b0, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd67108864, 1'b1, ST_OK,        26'd0},
        '{ROW_FREE,  27'd67108863, 1'b1, ST_OK,        26'd0},
        '{ROW_SHIFT, 27'd0,        1'b0, ST_OK,        26'd0},
        '{ROW_ALLOC, 27'd1024,     1'b1, ST_OK,        26'd0},
        '{ROW_FREE,  27'd1023,     1'b1, ST_OK,        26'd0},
        '{ROW_FREE,  27'd1024,     1'b1, ST_NOT_ALLOC, 26'd0},
        '{ROW_ALLOC, 27'd1025,     1'b1, ST_NO_SPACE,  26'd0}
    };

    initial begin : request_source
        int                 i;
        int                 p;
        int                 n;
        int                 k;
        int                 sh;
        int                 lvl;
        int                 r;
        int                 free_pct;
        bit                 steady;
        longint             hi;
        longint             lo;
        longint             b;
        logic               op;
        logic [BYTES_W-1:0] bytes;
        logic [OFF_W-1:0]   off;
        t_dir_row           row;
        int                 shift_plan [0:6];

        // shadow tree starts with every node at its own level
        shadow_shift = SHIFT_RESET;
        level_tree[0] = LEVELS;
        for (i = 1; i < NODE_CNT; i++)
            level_tree[i] = level_tree[(i - 1) / 2] - 1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (i = 0; i < 25; i++) begin
            row = dir_rows[i];
            case (row.kind)
                ROW_SHIFT: begin
                    write_shift(row.arg[SHIFT_W-1:0]);
                end
                ROW_ALLOC: begin
                    send_request(OP_ALLOC, row.arg, OFF_W'($urandom), row.typed,
                                 '{row.status, row.region}, 1'b0);
                end
                default: begin
                    send_request(OP_FREE, BYTES_W'($urandom_range(0, MAX_BYTES)),
                                 row.arg[OFF_W-1:0], row.typed,
                                 '{row.status, row.region}, 1'b0);
                end
            endcase
        end

        // random phases, one block_shift setting each
        shift_plan = '{16, 31, 0, 6, 1, 11, 0};
        shift_plan[6] = $urandom_range(0, 31);
        random_phase = 1'b1;
        steady = 1'b0;
        for (p = 0; p < 7; p++) begin
            write_shift(SHIFT_W'(shift_plan[p]));
            sh = eff_shift();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 64 == 0)
                    steady = ($urandom_range(0, 2) == 0);
                free_pct = 20 + 4 * live_blk.size();
                if (free_pct > 85)
                    free_pct = 85;
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // noise: arbitrary fields
                    op    = 1'($urandom_range(0, 1));
                    bytes = BYTES_W'($urandom_range(0, MAX_BYTES));
                    off   = OFF_W'($urandom);
                end else if (live_blk.size() > 0 && $urandom_range(0, 99) < free_pct) begin
                    // free a live region, at its start or anywhere inside
                    k = $urandom_range(0, live_blk.size() - 1);
                    b = live_blk[k];
                    if ($urandom_range(0, 2) != 0)
                        b += $urandom_range(0, (1 << live_lvl[k]) - 1);
                    op    = OP_FREE;
                    bytes = BYTES_W'($urandom_range(0, MAX_BYTES));
                    off   = OFF_W'(b << sh);
                    if ($urandom_range(0, 1) == 1)
                        off += OFF_W'($urandom_range(0, (1 << sh) - 1));
                end else begin
                    // allocate, mostly small sizes
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        lvl = $urandom_range(0, 2);
                    else if (r < 90)
                        lvl = $urandom_range(3, 6);
                    else
                        lvl = $urandom_range(7, LEVELS);
                    hi = (longint'(1) << lvl) << sh;
                    lo = (lvl == 0) ? 0 : hi / 2 + 1;
                    op    = OP_ALLOC;
                    bytes = BYTES_W'(lo + $urandom_range(0, int'(hi - lo)));
                    off   = OFF_W'($urandom);
                end
                send_request(op, bytes, off, 1'b0, '0, steady);
            end
        end
        random_phase = 1'b0;

        // drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over %0d block_shift settings:", n_requests,
                 n_settings + 1);
        $display("  %0d allocations, %0d out of space, %0d frees, %0d not allocated",
                 n_alloc_ok, n_no_space, n_free_ok, n_not_alloc);
        if (errors == 0)
            $display("tb_buddy_allocator_tree: PASS");
        else
            $display("tb_buddy_allocator_tree: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        int iter;
        bit steady;

        iter = 0;
        steady = 1'b0;
        forever begin
            if (iter % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            iter++;
            if (!pressure_done && random_phase && results_seen >= 150) begin
                // hold off while the request side keeps offering
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
            end else begin
                gap = pick_gap(steady);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d region_offset 0x%0h",
                       o_status, o_region_offset);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    errors++;
                end
                if (o_region_offset !== exp_res.region_offset) begin
                    $error("region_offset: expected 0x%0h, got 0x%0h",
                           exp_res.region_offset, o_region_offset);
                    errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT);
        $display("tb_buddy_allocator_tree: FAIL");
        $finish;
    end

endmodule
